/* src/pru_pkg.sv */
// Shared types, constants and helper functions of the pixel replicate upscaler.
// Used by every module of the block but pru_ram; depends on nothing else.
package pru_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int IDX_W     = $clog2(MAX_WIDTH + 1);
  localparam int PIX_W     = 24;
  localparam int SCALE_W   = 7;
  localparam int SRCW_W    = 13;
  localparam int ROWS_W    = 16;
  localparam int MAX_SCALE = 100;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_PAD       = 2'd1,
    KIND_NOT_READY = 2'd2,
    KIND_BUSY      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_WIDTH = 2'd1,
    REG_ROWS  = 2'd2
  } reg_idx_t;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [IDX_W-1:0]   width;
    logic [ROWS_W-1:0]  rows;
    logic [1:0]         pad;
    logic               clear;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  row_end;
    logic  image_end;
  } res_t;

  // Pad bytes to reach a 4-byte boundary of width * scale * 3.
  function automatic logic [1:0] pad_of(input logic [1:0] w, input logic [1:0] s);
    logic [5:0] prod;
    prod = 6'(w) * 6'(s) * 6'd3;
    return 2'(3'd4 - {1'b0, prod[1:0]});
  endfunction

endpackage

/* src/pru_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/pru_regs.sv */
// Configuration registers behind the APB-style port, with range clamping.
// Depends on pru_pkg.
module pru_regs
  import pru_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic [SRCW_W-1:0]  srcw_r, srcw_nxt;
  logic [ROWS_W-1:0]  rows_r, rows_nxt;
  logic               wr;
  logic               hit;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_comb begin
    scale_nxt = scale_r;
    srcw_nxt  = srcw_r;
    rows_nxt  = rows_r;
    hit       = 1'b0;
    prdata    = '0;
    unique case (idx)
      REG_SCALE: begin
        hit       = 1'b1;
        prdata    = CFG_DW'(scale_r);
        scale_nxt = pwdata[SCALE_W-1:0];
      end
      REG_WIDTH: begin
        hit      = 1'b1;
        prdata   = CFG_DW'(srcw_r);
        srcw_nxt = pwdata[SRCW_W-1:0];
      end
      REG_ROWS: begin
        hit      = 1'b1;
        prdata   = CFG_DW'(rows_r);
        rows_nxt = pwdata[ROWS_W-1:0];
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_W'(1);
      srcw_r  <= SRCW_W'(1);
      rows_r  <= ROWS_W'(1);
    end else if (wr) begin
      scale_r <= scale_nxt;
      srcw_r  <= srcw_nxt;
      rows_r  <= rows_nxt;
    end
  end

  always_comb begin
    if (scale_r == '0) begin
      cfg.scale = SCALE_W'(1);
    end else if (32'(scale_r) > MAX_SCALE) begin
      cfg.scale = SCALE_W'(MAX_SCALE);
    end else begin
      cfg.scale = scale_r;
    end
    if (srcw_r == '0) begin
      cfg.width = IDX_W'(1);
    end else if (32'(srcw_r) > MAX_WIDTH) begin
      cfg.width = IDX_W'(MAX_WIDTH);
    end else begin
      cfg.width = IDX_W'(srcw_r);
    end
    cfg.rows  = (rows_r == '0) ? ROWS_W'(1) : rows_r;
    cfg.pad   = pad_of(cfg.width[1:0], cfg.scale[1:0]);
    cfg.clear = wr && hit;
  end

endmodule

/* src/pru_ctrl.sv */
// Row sequencer: fill, horizontal and vertical copy, pad and row counters.
// Drives the row store ports and the control part of each result. Depends on pru_pkg.
module pru_ctrl
  import pru_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              accept,
  input  logic              command,
  input  logic [PIX_W-1:0]  pixel,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [PIX_W-1:0]  ram_wdata,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  output res_t              res
);

  logic [IDX_W-1:0]   fill_r, fill_nxt;
  logic               ready_r, ready_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [SCALE_W-1:0] hcopy_r, hcopy_nxt;
  logic [SCALE_W-1:0] vcopy_r, vcopy_nxt;
  logic [1:0]         padc_r, padc_nxt;
  logic [ROWS_W-1:0]  rows_r, rows_nxt;

  logic [IDX_W-1:0]   fill_inc, rd_inc, rd_new;
  logic [SCALE_W-1:0] hc_inc, vc_inc;
  logic [1:0]         pc_inc;
  logic [ROWS_W:0]    rows_inc;
  logic               last;

  assign fill_inc = fill_r + IDX_W'(1);
  assign rd_inc   = rd_idx_r + IDX_W'(1);
  assign hc_inc   = hcopy_r + SCALE_W'(1);
  assign vc_inc   = vcopy_r + SCALE_W'(1);
  assign pc_inc   = padc_r + 2'd1;
  assign rows_inc = {1'b0, rows_r} + (ROWS_W+1)'(1);

  assign ram_waddr = fill_r[ADDR_W-1:0];
  assign ram_wdata = pixel;
  assign ram_raddr = rd_idx_r[ADDR_W-1:0];

  always_comb begin
    fill_nxt   = fill_r;
    ready_nxt  = ready_r;
    rd_idx_nxt = rd_idx_r;
    hcopy_nxt  = hcopy_r;
    vcopy_nxt  = vcopy_r;
    padc_nxt   = padc_r;
    rows_nxt   = rows_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    rd_new     = rd_idx_r;
    last       = 1'b0;
    res        = '{valid: 1'b0, kind: KIND_PIXEL, row_end: 1'b0, image_end: 1'b0};

    if (accept && command == CMD_PUSH) begin
      if (ready_r) begin
        res.valid = 1'b1;
        res.kind  = KIND_BUSY;
      end else begin
        ram_we   = fill_r < cfg.width;
        fill_nxt = ram_we ? fill_inc : fill_r;
        if (fill_nxt >= cfg.width) begin
          ready_nxt  = 1'b1;
          rd_idx_nxt = '0;
          hcopy_nxt  = '0;
          vcopy_nxt  = '0;
          padc_nxt   = '0;
        end
      end
    end else if (accept) begin
      res.valid = 1'b1;
      if (!ready_r) begin
        res.kind = KIND_NOT_READY;
      end else begin
        if (rd_idx_r < cfg.width) begin
          ram_re   = 1'b1;
          res.kind = KIND_PIXEL;
          if (hc_inc >= cfg.scale) begin
            hcopy_nxt = '0;
            rd_new    = rd_inc;
          end else begin
            hcopy_nxt = hc_inc;
          end
          rd_idx_nxt = rd_new;
          last       = (rd_new >= cfg.width) && (cfg.pad == 2'd0);
        end else begin
          res.kind = KIND_PAD;
          padc_nxt = pc_inc;
          last     = pc_inc >= cfg.pad;
        end
        if (last) begin
          rd_idx_nxt = '0;
          hcopy_nxt  = '0;
          padc_nxt   = '0;
          if (vc_inc >= cfg.scale) begin
            vcopy_nxt = '0;
            ready_nxt = 1'b0;
            fill_nxt  = '0;
            if (rows_inc >= {1'b0, cfg.rows}) begin
              res.image_end = 1'b1;
              rows_nxt      = '0;
            end else begin
              rows_nxt = rows_inc[ROWS_W-1:0];
            end
          end else begin
            vcopy_nxt = vc_inc;
          end
        end
        res.row_end = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.clear) begin
      fill_r   <= '0;
      ready_r  <= 1'b0;
      rd_idx_r <= '0;
      hcopy_r  <= '0;
      vcopy_r  <= '0;
      padc_r   <= '0;
      rows_r   <= '0;
    end else begin
      fill_r   <= fill_nxt;
      ready_r  <= ready_nxt;
      rd_idx_r <= rd_idx_nxt;
      hcopy_r  <= hcopy_nxt;
      vcopy_r  <= vcopy_nxt;
      padc_r   <= padc_nxt;
      rows_r   <= rows_nxt;
    end
  end

endmodule

/* src/pru_pipe.sv */
// Result pipeline: a stage aligned with the row store read, then the output register.
// Depends on pru_pkg.
module pru_pipe
  import pru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  res_t             res,
  input  logic [PIX_W-1:0] ram_rdata,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_item_kind,
  output logic [7:0]       out_blue_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_red_out,
  output logic             out_row_end,
  output logic             out_image_end
);

  res_t             s1_r;
  logic             out_v_r;
  kind_t            kind_r;
  logic             row_end_r, img_end_r;
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic             out_move, s1_free;

  assign out_move = !out_v_r || !out_stall;
  assign s1_free  = !s1_r.valid || out_move;
  assign in_stall = !s1_free;
  assign pix_nxt  = (s1_r.kind == KIND_PIXEL) ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_r.valid <= accept && res.valid;
      end
      if (out_move) begin
        out_v_r <= s1_r.valid;
      end
    end
    if (s1_free) begin
      s1_r.kind      <= res.kind;
      s1_r.row_end   <= res.row_end;
      s1_r.image_end <= res.image_end;
    end
    if (out_move) begin
      kind_r    <= s1_r.kind;
      row_end_r <= s1_r.row_end;
      img_end_r <= s1_r.image_end;
      pix_r     <= pix_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_item_kind = kind_r;
  assign out_blue_out  = pix_r[7:0];
  assign out_green_out = pix_r[15:8];
  assign out_red_out   = pix_r[23:16];
  assign out_row_end   = row_end_r;
  assign out_image_end = img_end_r;

endmodule

/* src/pixel_replicate_upscaler_core.sv */
// Integer nearest-neighbor upscaler for 24-bit pixel rows. Push words fill a one-row store;
// once a full row is in, each pull word returns the next pixel copy or pad byte, and the row
// is read out scale times. One word is accepted every cycle unless in_stall holds the input; a
// result passes through the registered read of the row store RAM and then the output register.
// The row store needs no clearing pass after reset.
module pixel_replicate_upscaler_core
  import pru_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [7:0]        in_blue_in,
  input  logic [7:0]        in_green_in,
  input  logic [7:0]        in_red_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_item_kind,
  output logic [7:0]        out_blue_out,
  output logic [7:0]        out_green_out,
  output logic [7:0]        out_red_out,
  output logic              out_row_end,
  output logic              out_image_end
);

  cfg_t              cfg;
  res_t              res;
  logic              accept;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;

  assign accept = in_valid && !in_stall;

  pru_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .accept    (accept),
    .command   (in_command),
    .pixel     ({in_red_in, in_green_in, in_blue_in}),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .res       (res)
  );

  pru_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pru_pipe u_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .res           (res),
    .ram_rdata     (ram_rdata),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item_kind (out_item_kind),
    .out_blue_out  (out_blue_out),
    .out_green_out (out_green_out),
    .out_red_out   (out_red_out),
    .out_row_end   (out_row_end),
    .out_image_end (out_image_end)
  );

`ifndef ASSERT_OFF
  a_img_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_row_end)
    else $error("image end without row end");

  a_nonpixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind != KIND_PIXEL |->
      out_blue_out == 8'd0 && out_green_out == 8'd0 && out_red_out == 8'd0)
    else $error("non-pixel word carries color");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output side is free");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("row store written and read in one cycle");
`endif

endmodule

/* tb/tb_pixel_replicate_upscaler_core.sv */
// Self-checking testbench for pixel_replicate_upscaler_core: directed table, then fixed and random images.
// Holds its own row-replication predictor; depends on pru_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_pixel_replicate_upscaler_core
  import pru_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned RANDOM_WORDS = 200;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       image_end;
  } result_t;

  typedef struct {
    bit          setting;
    logic [1:0]  idx;
    logic [31:0] value;
    logic        cmd;
    logic [23:0] pix;
    bit          typed;
    result_t     want;
  } step_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_command = CMD_PUSH;
  logic [7:0]        in_blue_in = '0;
  logic [7:0]        in_green_in = '0;
  logic [7:0]        in_red_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_item_kind;
  logic [7:0]        out_blue_out;
  logic [7:0]        out_green_out;
  logic [7:0]        out_red_out;
  logic              out_row_end;
  logic              out_image_end;

  logic [6:0]  scale_reg = 7'd1;
  logic [12:0] width_reg = 13'd1;
  logic [15:0] rows_reg = 16'd1;
  logic [23:0] pix_store [0:MAX_WIDTH-1];
  int unsigned fill_cnt = 0;
  int unsigned col_idx = 0;
  int unsigned hrep = 0;
  int unsigned vrep = 0;
  int unsigned pad_seen = 0;
  int unsigned rows_out = 0;
  bit          line_ready = 1'b0;

  result_t     expected_items[$];
  step_t       directed_steps[$];
  result_t     seen_want;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned useful_words = 0;
  int unsigned results_checked = 0;
  int unsigned image_ends = 0;
  int unsigned settings_written = 0;
  int unsigned cycle_count = 0;

  pixel_replicate_upscaler_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_blue_in    (in_blue_in),
    .in_green_in   (in_green_in),
    .in_red_in     (in_red_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item_kind (out_item_kind),
    .out_blue_out  (out_blue_out),
    .out_green_out (out_green_out),
    .out_red_out   (out_red_out),
    .out_row_end   (out_row_end),
    .out_image_end (out_image_end)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff_scale();
    if (scale_reg < 1) return 1;
    if (scale_reg > MAX_SCALE) return MAX_SCALE;
    return int'(scale_reg);
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg < 1) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int unsigned eff_rows();
    return (rows_reg < 1) ? 1 : int'(rows_reg);
  endfunction

  function automatic int unsigned row_pad();
    return (4 - (eff_width() * eff_scale() * 3) % 4) % 4;
  endfunction

  // Advances the replication state by one word; returns 1 when the word yields a result.
  function automatic bit predict_upscale(input logic cmd, input logic [23:0] pix,
                                         output result_t res);
    int unsigned w;
    int unsigned s;
    int unsigned pad;
    bit last;
    w = eff_width();
    s = eff_scale();
    pad = row_pad();
    last = 1'b0;
    res = '0;
    res.kind = KIND_PIXEL;
    if (cmd == CMD_PUSH) begin
      if (line_ready) begin
        res.kind = KIND_BUSY;
        return 1'b1;
      end
      if (fill_cnt < w) begin
        pix_store[fill_cnt] = pix;
        fill_cnt++;
      end
      if (fill_cnt >= w) begin
        line_ready = 1'b1;
        col_idx = 0;
        hrep = 0;
        vrep = 0;
        pad_seen = 0;
      end
      return 1'b0;
    end
    if (!line_ready) begin
      res.kind = KIND_NOT_READY;
      return 1'b1;
    end
    if (col_idx < w) begin
      {res.red, res.green, res.blue} = pix_store[col_idx];
      hrep++;
      if (hrep >= s) begin
        hrep = 0;
        col_idx++;
      end
      last = (col_idx >= w) && (pad == 0);
    end else begin
      res.kind = KIND_PAD;
      pad_seen++;
      last = pad_seen >= pad;
    end
    if (last) begin
      col_idx = 0;
      hrep = 0;
      pad_seen = 0;
      vrep++;
      if (vrep >= s) begin
        vrep = 0;
        line_ready = 1'b0;
        fill_cnt = 0;
        rows_out++;
        if (rows_out >= eff_rows()) begin
          res.image_end = 1'b1;
          rows_out = 0;
        end
      end
    end
    res.row_end = last;
    return 1'b1;
  endfunction

  function automatic void add_step(input bit setting, input logic [1:0] idx,
                                   input logic [31:0] value, input logic cmd,
                                   input logic [23:0] pix, input bit typed,
                                   input result_t want);
    step_t st;
    st.setting = setting;
    st.idx = idx;
    st.value = value;
    st.cmd = cmd;
    st.pix = pix;
    st.typed = typed;
    st.want = want;
    directed_steps.push_back(st);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s at %0t ns: got 0x%0h, expected 0x%0h", what, $time, got, want);
    mismatches++;
  endtask

  task automatic send_word(input logic cmd, input logic [23:0] pix, input bit typed,
                           input result_t typed_want);
    result_t want;
    bit has;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_red_in <= pix[23:16];
    in_green_in <= pix[15:8];
    in_blue_in <= pix[7:0];
    do @(posedge clk); while (in_stall);
    has = predict_upscale(cmd, pix, want);
    if (has) expected_items.push_back(typed ? typed_want : want);
    words_sent++;
    if (!(has && want.kind == KIND_BUSY)) useful_words++;
  endtask

  task automatic maybe_noise(input bit noisy);
    if (noisy && $urandom_range(0, 15) == 0) begin
      send_word(logic'($urandom_range(0, 1)), 24'($urandom()), 1'b0, '0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register access; a write also updates the predictor, a read is compared with data.
  task automatic cfg_access(input bit wr, input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wr ? data : '0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata !== data) report_mismatch("register read", prdata, data);
    psel <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      case (idx)
        REG_SCALE: scale_reg = data[6:0];
        REG_WIDTH: width_reg = data[12:0];
        REG_ROWS:  rows_reg = data[15:0];
        default: ;
      endcase
      if (idx != REG_SPARE) begin
        fill_cnt = 0;
        line_ready = 1'b0;
        col_idx = 0;
        hrep = 0;
        vrep = 0;
        pad_seen = 0;
        rows_out = 0;
        settings_written++;
      end
    end
    @(posedge clk);
  endtask

  task automatic run_image(input int unsigned s_val, input int unsigned w_val,
                           input int unsigned r_val, input int unsigned n_rows,
                           input int unsigned n_copies, input bit noisy);
    int unsigned copies;
    int unsigned row_len;
    settle();
    cfg_access(1'b1, REG_SCALE, s_val);
    cfg_access(1'b1, REG_WIDTH, w_val);
    cfg_access(1'b1, REG_ROWS, r_val);
    cfg_access(1'b0, REG_SCALE, s_val & 32'h7F);
    cfg_access(1'b0, REG_WIDTH, w_val & 32'h1FFF);
    cfg_access(1'b0, REG_ROWS, r_val & 32'hFFFF);
    copies = (n_copies < eff_scale()) ? n_copies : eff_scale();
    row_len = eff_width() * eff_scale() + row_pad();
    repeat (n_rows) begin
      repeat (eff_width()) begin
        maybe_noise(noisy);
        send_word(CMD_PUSH, 24'($urandom()), 1'b0, '0);
      end
      repeat (copies) begin
        repeat (row_len) begin
          maybe_noise(noisy);
          send_word(CMD_PULL, 24'($urandom()), 1'b0, '0);
        end
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_items.size() == 0) begin
        report_mismatch("word with none expected, kind", out_item_kind, 0);
      end else begin
        seen_want = expected_items.pop_front();
        results_checked++;
        if (out_image_end) image_ends++;
        if (out_item_kind !== seen_want.kind)
          report_mismatch("item_kind", out_item_kind, seen_want.kind);
        if (out_red_out !== seen_want.red) report_mismatch("red_out", out_red_out, seen_want.red);
        if (out_green_out !== seen_want.green)
          report_mismatch("green_out", out_green_out, seen_want.green);
        if (out_blue_out !== seen_want.blue)
          report_mismatch("blue_out", out_blue_out, seen_want.blue);
        if (out_row_end !== seen_want.row_end)
          report_mismatch("row_end", out_row_end, seen_want.row_end);
        if (out_image_end !== seen_want.image_end)
          report_mismatch("image_end", out_image_end, seen_want.image_end);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
             expected_items.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned random_start;
    int unsigned rows_pick;
    add_step(0, REG_SCALE, 0, CMD_PULL, 24'h0, 1, {KIND_NOT_READY, 24'h0, 1'b0, 1'b0});
    add_step(0, REG_SCALE, 0, CMD_PUSH, 24'hFFFFFF, 0, '0);
    add_step(0, REG_SCALE, 0, CMD_PUSH, 24'h000000, 1, {KIND_BUSY, 24'h0, 1'b0, 1'b0});
    add_step(1, REG_SPARE, 32'hFFFFFFFF, CMD_PUSH, 24'h0, 0, '0);
    add_step(0, REG_SCALE, 0, CMD_PULL, 24'h0, 1, {KIND_PIXEL, 24'hFFFFFF, 1'b0, 1'b0});
    add_step(0, REG_SCALE, 0, CMD_PULL, 24'h0, 1, {KIND_PAD, 24'h0, 1'b1, 1'b1});
    add_step(0, REG_SCALE, 0, CMD_PULL, 24'h0, 1, {KIND_NOT_READY, 24'h0, 1'b0, 1'b0});
    add_step(0, REG_SCALE, 0, CMD_PUSH, 24'h000000, 0, '0);
    add_step(0, REG_SCALE, 0, CMD_PULL, 24'hFFFFFF, 1, {KIND_PIXEL, 24'h000000, 1'b0, 1'b0});
    add_step(0, REG_SCALE, 0, CMD_PULL, 24'h0, 1, {KIND_PAD, 24'h0, 1'b1, 1'b1});
    add_step(1, REG_SCALE, 2, CMD_PUSH, 24'h0, 0, '0);
    add_step(1, REG_WIDTH, 2, CMD_PUSH, 24'h0, 0, '0);
    add_step(1, REG_ROWS, 2, CMD_PUSH, 24'h0, 0, '0);
    add_step(0, REG_SCALE, 0, CMD_PUSH, 24'hA55AC3, 0, '0);
    add_step(0, REG_SCALE, 0, CMD_PUSH, 24'h3CC35A, 0, '0);
    add_step(0, REG_SCALE, 0, CMD_PUSH, 24'h5AA53C, 1, {KIND_BUSY, 24'h0, 1'b0, 1'b0});
    repeat (8) add_step(0, REG_SCALE, 0, CMD_PULL, 24'h0, 0, '0);
    add_step(0, REG_SCALE, 0, CMD_PULL, 24'h0, 1, {KIND_NOT_READY, 24'h0, 1'b0, 1'b0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].setting) begin
        settle();
        cfg_access(1'b1, directed_steps[i].idx, directed_steps[i].value);
      end else begin
        send_word(directed_steps[i].cmd, directed_steps[i].pix, directed_steps[i].typed,
                  directed_steps[i].want);
      end
    end

    hold_req = 1'b1;
    run_image(2, 3, 2, 2, 100, 1'b0);
    run_image(0, 0, 0, 2, 100, 1'b1);
    run_image(127, 1, 65535, 1, 2, 1'b0);
    run_image(1, 8191, 1, 0, 0, 1'b0);
    run_image(100, 4096, 1, 0, 0, 1'b0);

    random_start = useful_words;
    while (useful_words - random_start < RANDOM_WORDS) begin
      rows_pick = $urandom_range(1, 3);
      run_image($urandom_range(1, 4), $urandom_range(1, 8), rows_pick,
                rows_pick + ($urandom_range(0, 4) == 0), 100, 1'b1);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, eff_width())) send_word(CMD_PUSH, 24'($urandom()), 1'b0, '0);
      end
    end

    calm = 1'b1;
    run_image(2, 5, 2, 2, 100, 1'b0);
    settle();

    $display("Sent %0d words (%0d random) over %0d register writes;", words_sent,
             useful_words - random_start, settings_written);
    $display("checked %0d results, %0d image ends, with clamped settings and a long hold.",
             results_checked, image_ends);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/pru_pkg.sv
src/pru_ram.sv
src/pru_regs.sv
src/pru_ctrl.sv
src/pru_pipe.sv
src/pixel_replicate_upscaler_core.sv
tb/tb_pixel_replicate_upscaler_core.sv
